>>> rtl/lcbc_pkg.sv
// Package for the Luhn card brand check unit: widths, brand codes, FSM states,
// cell control struct and the small digit/range helper functions.
// No dependencies.
package lcbc_pkg;

    localparam int CARD_W     = 63;
    localparam int MAX_DIGITS = 19;
    localparam int DIGIT_W    = 4;
    localparam int CHUNK_W    = 4;
    localparam int CONV_STEPS = (CARD_W + CHUNK_W - 1) / CHUNK_W;
    localparam int NUM_W      = CONV_STEPS * CHUNK_W;
    localparam int SUM_STEPS  = (MAX_DIGITS + 1) / 2;
    localparam int MAX_STEPS  = (CONV_STEPS > SUM_STEPS) ? CONV_STEPS : SUM_STEPS;
    localparam int CNT_W      = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int SUM_W      = DIGIT_W + 1;

    localparam logic [CARD_W-1:0] AMEX_LO_A = 63'd340000000000000;
    localparam logic [CARD_W-1:0] AMEX_HI_A = 63'd349999999999999;
    localparam logic [CARD_W-1:0] AMEX_LO_B = 63'd370000000000000;
    localparam logic [CARD_W-1:0] AMEX_HI_B = 63'd379999999999999;
    localparam logic [CARD_W-1:0] MC_LO     = 63'd5100000000000000;
    localparam logic [CARD_W-1:0] MC_HI     = 63'd5599999999999999;
    localparam logic [CARD_W-1:0] VISA_LO_A = 63'd4000000000000;
    localparam logic [CARD_W-1:0] VISA_HI_A = 63'd4999999999999;
    localparam logic [CARD_W-1:0] VISA_LO_B = 63'd4000000000000000;
    localparam logic [CARD_W-1:0] VISA_HI_B = 63'd4999999999999999;

    typedef enum logic [1:0] {
        BRAND_INVALID    = 2'd0,
        BRAND_AMEX       = 2'd1,
        BRAND_MASTERCARD = 2'd2,
        BRAND_VISA       = 2'd3
    } brand_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SUM,
        ST_DONE
    } lcbc_state_t;

    typedef struct packed {
        logic clear;
        logic conv;
        logic shift;
    } cell_ctrl_t;

    // Luhn value of a doubled digit: tens plus ones of 2*d
    function automatic logic [DIGIT_W-1:0] dbl_digit(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W:0] t;
        t = {d, 1'b0};
        if (t >= SUM_W'(10))
        begin
            t = t - SUM_W'(9);
        end
        return t[DIGIT_W-1:0];
    endfunction

    // (acc + a + b) mod 10, all inputs below ten
    function automatic logic [DIGIT_W-1:0] add_mod10(input logic [DIGIT_W-1:0] acc,
                                                    input logic [DIGIT_W-1:0] a,
                                                    input logic [DIGIT_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(acc) + SUM_W'(a) + SUM_W'(b);
        if (s >= SUM_W'(20))
        begin
            s = s - SUM_W'(20);
        end
        else if (s >= SUM_W'(10))
        begin
            s = s - SUM_W'(10);
        end
        return s[DIGIT_W-1:0];
    endfunction

    function automatic brand_t classify(input logic [CARD_W-1:0] v);
        brand_t b;
        if ((v >= AMEX_LO_A && v <= AMEX_HI_A) || (v >= AMEX_LO_B && v <= AMEX_HI_B))
        begin
            b = BRAND_AMEX;
        end
        else if (v >= MC_LO && v <= MC_HI)
        begin
            b = BRAND_MASTERCARD;
        end
        else if ((v >= VISA_LO_A && v <= VISA_HI_A) || (v >= VISA_LO_B && v <= VISA_HI_B))
        begin
            b = BRAND_VISA;
        end
        else
        begin
            b = BRAND_INVALID;
        end
        return b;
    endfunction

endpackage

>>> rtl/lcbc_in_if.sv
// Input channel of the Luhn card brand check unit: one card number per beat.
// Depends on lcbc_pkg.
interface lcbc_in_if;
    import lcbc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CARD_W-1:0] card_number;

    modport source (output valid, output card_number, input ready);
    modport sink   (input valid, input card_number, output ready);
endinterface

>>> rtl/lcbc_out_if.sv
// Result channel of the Luhn card brand check unit: checksum flag and brand per beat.
// Depends on lcbc_pkg.
interface lcbc_out_if;
    import lcbc_pkg::*;

    logic       valid;
    logic       ready;
    logic       checksum_ok;
    logic [1:0] brand;

    modport source (output valid, output checksum_ok, output brand, input ready);
    modport sink   (input valid, input checksum_ok, input brand, output ready);
endinterface

>>> rtl/luhn_card_brand_check_unit.sv
// Luhn card brand check unit: top level with control FSM, digit cell chain and
// result register. Depends on lcbc_pkg, lcbc_in_if, lcbc_out_if, lcbc_digit_cell.
//
// Usage:
//   card_in carries one 63-bit card number per beat (valid/ready). result_out
//   carries checksum_ok and brand per beat; brand is 0 unless checksum_ok is 1.
//   One result beat is produced for every input beat, in order.
//   Processing: in ST_CONV an accepted number converts to decimal in a row of
//   MAX_DIGITS BCD cells, four binary bits per cycle; in ST_SUM the digits shift
//   two places a cycle into a mod-10 accumulator; in ST_DONE the result
//   register is loaded as soon as it is free.
//   Throughput: one number at a time; the shared cell row takes no new number
//   until the last one has reached ST_DONE and been loaded out.
//   card_in.ready is high only while no number is in the cell row. A finished
//   result waits in the output register while the next number is accepted; if
//   the receiver still stalls when the next result is ready, the unit holds that
//   result in its accumulator and stays busy until the output register frees.
//   Reset (rst_n low, asynchronous) empties the unit and drops any result.
module luhn_card_brand_check_unit
(
    input  logic       clk,
    input  logic       rst_n,
    lcbc_in_if.sink    card_in,
    lcbc_out_if.source result_out
);
    import lcbc_pkg::*;

    lcbc_state_t        state_reg;
    lcbc_state_t        state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [NUM_W-1:0]   num_reg;
    logic [NUM_W-1:0]   num_next;
    logic [DIGIT_W-1:0] acc_reg;
    logic [DIGIT_W-1:0] acc_next;
    brand_t             cls_reg;
    brand_t             cls_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_ok_reg;
    logic               out_ok_next;
    brand_t             out_brand_reg;
    brand_t             out_brand_next;

    logic               accept;
    logic               out_free;
    logic               load_out;
    cell_ctrl_t         cell_ctrl;
    logic [CHUNK_W-1:0] first_bits;

    logic [CHUNK_W-1:0] chain_bits [MAX_DIGITS];
    logic [DIGIT_W-1:0] digits     [MAX_DIGITS];

    assign out_free = !out_valid_reg || result_out.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (card_in.valid)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        card_in.ready   = 1'b0;
        cell_ctrl.clear = 1'b0;
        cell_ctrl.conv  = 1'b0;
        cell_ctrl.shift = 1'b0;
        load_out        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                card_in.ready   = 1'b1;
                cell_ctrl.clear = card_in.valid;
            end
            ST_CONV:
            begin
                cell_ctrl.conv = 1'b1;
            end
            ST_SUM:
            begin
                cell_ctrl.shift = 1'b1;
            end
            ST_DONE:
            begin
                load_out = out_free;
            end
            default:
            begin
                card_in.ready = 1'b0;
            end
        endcase
    end

    assign accept = card_in.valid && card_in.ready;

    // top chunk enters cell 0 most significant bit first
    always_comb
    begin
        for (int s = 0; s < CHUNK_W; s++)
        begin
            first_bits[s] = num_reg[NUM_W-1-s];
        end
    end

    for (genvar i = 0; i < MAX_DIGITS; i++)
    begin : g_cell
        logic [CHUNK_W-1:0] cell_bits_in;
        logic [DIGIT_W-1:0] cell_shift_in;

        if (i == 0)
        begin : g_first
            assign cell_bits_in = first_bits;
        end
        else
        begin : g_rest
            assign cell_bits_in = chain_bits[i-1];
        end

        if (i + 2 < MAX_DIGITS)
        begin : g_shift
            assign cell_shift_in = digits[i+2];
        end
        else
        begin : g_shift_end
            assign cell_shift_in = '0;
        end

        lcbc_digit_cell u_cell
        (
            .clk      (clk),
            .ctrl     (cell_ctrl),
            .bits_in  (cell_bits_in),
            .shift_in (cell_shift_in),
            .bits_out (chain_bits[i]),
            .digit    (digits[i])
        );
    end

    // datapath
    always_comb
    begin
        cnt_next = cnt_reg;
        num_next = num_reg;
        acc_next = acc_reg;
        cls_next = cls_reg;
        if (accept)
        begin
            cnt_next = CNT_W'(CONV_STEPS - 1);
            num_next = NUM_W'(card_in.card_number);
            acc_next = '0;
            cls_next = classify(card_in.card_number);
        end
        else if (state_reg == ST_CONV)
        begin
            num_next = num_reg << CHUNK_W;
            cnt_next = (cnt_reg == '0) ? CNT_W'(SUM_STEPS - 1) : cnt_reg - 1'b1;
        end
        else if (state_reg == ST_SUM)
        begin
            acc_next = add_mod10(acc_reg, digits[0], dbl_digit(digits[1]));
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        out_ok_next    = out_ok_reg;
        out_brand_next = out_brand_reg;
        out_valid_next = out_valid_reg && !result_out.ready;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_ok_next    = (acc_reg == '0);
            out_brand_next = (acc_reg == '0) ? cls_reg : BRAND_INVALID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg       <= num_next;
        acc_reg       <= acc_next;
        cls_reg       <= cls_next;
        out_ok_reg    <= out_ok_next;
        out_brand_reg <= out_brand_next;
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.checksum_ok = out_ok_reg;
    assign result_out.brand       = out_brand_reg;

endmodule

>>> rtl/lcbc_digit_cell.sv
// One BCD digit cell of the conversion chain: CHUNK_W shift-and-add-3 steps per
// cycle during conversion, then a two-place digit shift while summing.
// Depends on lcbc_pkg.
module lcbc_digit_cell
(
    input  logic                         clk,
    input  lcbc_pkg::cell_ctrl_t         ctrl,
    input  logic [lcbc_pkg::CHUNK_W-1:0] bits_in,
    input  logic [lcbc_pkg::DIGIT_W-1:0] shift_in,
    output logic [lcbc_pkg::CHUNK_W-1:0] bits_out,
    output logic [lcbc_pkg::DIGIT_W-1:0] digit
);
    import lcbc_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] conv_val;

    always_comb
    begin : dabble
        logic [DIGIT_W-1:0] d;
        logic [DIGIT_W-1:0] adj;
        d   = digit_reg;
        adj = '0;
        for (int s = 0; s < CHUNK_W; s++)
        begin
            adj         = (d >= DIGIT_W'(5)) ? d + DIGIT_W'(3) : d;
            bits_out[s] = adj[DIGIT_W-1];
            d           = {adj[DIGIT_W-2:0], bits_in[s]};
        end
        conv_val = d;
    end

    always_comb
    begin
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.conv)
        begin
            digit_next = conv_val;
        end
        else if (ctrl.shift)
        begin
            digit_next = shift_in;
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

>>> rtl/lcbc_checker.sv
// Port-level checks for the Luhn card brand check unit, bound to the top level.
// Depends on lcbc_pkg and luhn_card_brand_check_unit.
module lcbc_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [lcbc_pkg::CARD_W-1:0] card_number,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        checksum_ok,
    input logic [1:0]                  brand
);
    import lcbc_pkg::*;

    logic in_beat;

    assign in_beat = in_valid && in_ready;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(checksum_ok) && $stable(brand))
        else $error("result changed while stalled");

    // failed checksum never carries a brand
    a_brand_gated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !checksum_ok |-> brand == BRAND_INVALID)
        else $error("brand set on failed checksum");

    // busy right after a beat is taken
    a_busy_1: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !in_ready)
        else $error("ready one cycle after accept");

    a_busy_2: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |-> ##2 !in_ready)
        else $error("ready two cycles after accept");

    // card number is sampled only on a beat
    a_num_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |-> !$isunknown(card_number))
        else $error("unknown card number on accepted beat");

endmodule

bind luhn_card_brand_check_unit lcbc_checker u_lcbc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (card_in.valid),
    .in_ready    (card_in.ready),
    .card_number (card_in.card_number),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .checksum_ok (result_out.checksum_ok),
    .brand       (result_out.brand)
);
